[rtl/sbec_pkg.sv]
// ----------------------------------------------------------------------------
// sbec_pkg
// Shared types, constants and helpers of the symbol bitmap equivalence check.
// ----------------------------------------------------------------------------
package sbec_pkg;

  localparam int GRID    = 9;
  localparam int MAX_DIM = 256;
  localparam int CELLS   = GRID * GRID;
  localparam int DIM_W   = 9;
  localparam int POS_W   = 8;
  localparam int IDX_W   = 7;
  localparam int CNT_W   = 10;
  localparam int TOT_W   = 17;
  localparam int CAUSE_W = 3;
  localparam int CIDX_W  = 8;

  localparam logic [25:0] PI_Q24 = 26'd52707179;

  localparam logic [CIDX_W-1:0] REG_WIDTH  = 8'd0;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 8'd1;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 3'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_DIFF  = 3'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_HLINE = 3'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_VLINE = 3'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_DIAG  = 3'd4;
  localparam logic [CAUSE_W-1:0] CAUSE_CLUST = 3'd5;

  typedef struct packed {
    logic [CNT_W-1:0] tot;
    logic [CNT_W-1:0] left;
    logic [CNT_W-1:0] top;
  } cell_t;

  typedef struct packed {
    logic             diff;
    logic             last;
    logic [IDX_W-1:0] idx;
    logic             left;
    logic             top;
    logic [TOT_W-1:0] on_total;
    logic [TOT_W-1:0] diff_total;
  } qent_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = 9'd1;
    else if (v > 9'(MAX_DIM)) r = 9'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  // floor(v/9) for v up to 256
  function automatic logic [4:0] div9(input logic [DIM_W-1:0] v);
    logic [14:0] p;
    p = {6'b0, v} * 15'd57;
    return p[13:9];
  endfunction

endpackage

[rtl/sbec_fifo.sv]
// ----------------------------------------------------------------------------
// sbec_fifo
// Short queue of classified pixel events between front and back.
// ----------------------------------------------------------------------------
module sbec_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           flush,
  input  logic           push,
  input  sbec_pkg::qent_t wdata,
  input  logic           pop,
  output sbec_pkg::qent_t rdata,
  output logic           full,
  output logic           empty
);
  import sbec_pkg::*;

  qent_t      mem [0:3];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;

  assign full  = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= wptr + 2'd1;
      if (pop && !empty) rptr <= rptr + 2'd1;
      count <= count + 3'((push && !full) ? 1 : 0) - 3'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

[rtl/sbec_front.sv]
// ----------------------------------------------------------------------------
// sbec_front
// Takes pixel pairs, tracks position, cell and half, and queues events.
// ----------------------------------------------------------------------------
module sbec_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      accept,
  input  logic                      first_pixel,
  input  logic                      second_pixel,
  input  logic [sbec_pkg::DIM_W-1:0] w_dim,
  input  logic [sbec_pkg::DIM_W-1:0] h_dim,
  output logic                      push,
  output sbec_pkg::qent_t           entry
);
  import sbec_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [3:0]       c;
    logic [4:0]       off;
  } walk_t;

  walk_t            col;
  walk_t            row;
  logic [TOT_W-1:0] on_cnt;
  logic [TOT_W-1:0] diff_cnt;

  function automatic logic [4:0] cell_w(input walk_t s, input logic [DIM_W-1:0] dim);
    logic [4:0] part;
    logic [8:0] rem;
    part = div9(dim);
    rem  = dim - ({1'b0, part, 3'b0} + {4'b0, part});
    return ({5'b0, s.c} < rem) ? part + 5'd1 : part;
  endfunction

  function automatic walk_t walk_adv(input walk_t s, input logic [DIM_W-1:0] dim);
    walk_t n;
    n = s;
    if ({1'b0, s.pos} + 9'd1 == dim) begin
      n = '0;
    end else begin
      n.pos = s.pos + 8'd1;
      if (s.off + 5'd1 == cell_w(s, dim)) begin
        n.off = '0;
        if (s.c != 4'(GRID - 1)) n.c = s.c + 4'd1;
      end else begin
        n.off = s.off + 5'd1;
      end
    end
    return n;
  endfunction

  logic             col_last;
  logic             row_last;
  logic             d;
  logic [TOT_W-1:0] on_next;
  logic [TOT_W-1:0] diff_next;

  always_comb begin
    col_last  = ({1'b0, col.pos} + 9'd1 == w_dim);
    row_last  = ({1'b0, row.pos} + 9'd1 == h_dim);
    d         = first_pixel ^ second_pixel;
    on_next   = on_cnt + TOT_W'(first_pixel);
    diff_next = diff_cnt + TOT_W'(d);
    entry.diff       = d;
    entry.last       = col_last && row_last;
    entry.idx        = {col.c, 3'b0} + {3'b0, col.c} + {3'b0, row.c};
    entry.left       = col.off < (cell_w(col, w_dim) >> 1);
    entry.top        = row.off < (cell_w(row, h_dim) >> 1);
    entry.on_total   = on_next;
    entry.diff_total = diff_next;
    push = accept && (d || (col_last && row_last));
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col      <= '0;
      row      <= '0;
      on_cnt   <= '0;
      diff_cnt <= '0;
    end else if (accept) begin
      col <= walk_adv(col, w_dim);
      if (col_last) row <= walk_adv(row, h_dim);
      if (col_last && row_last) begin
        on_cnt   <= '0;
        diff_cnt <= '0;
      end else begin
        on_cnt   <= on_next;
        diff_cnt <= diff_next;
      end
    end
  end

endmodule

[rtl/sbec_back.sv]
// ----------------------------------------------------------------------------
// sbec_back
// Updates the cell count memory and sweeps it for the verdict at image end.
// ----------------------------------------------------------------------------
module sbec_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic [sbec_pkg::DIM_W-1:0]  w_dim,
  input  logic [sbec_pkg::DIM_W-1:0]  h_dim,
  input  sbec_pkg::qent_t             entry,
  input  logic                        empty,
  output logic                        pop,
  output logic                        clearing,
  output logic                        done,
  output logic                        equivalent,
  output logic [sbec_pkg::CAUSE_W-1:0] reject_cause
);
  import sbec_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_RUN    = 3'd1;
  localparam logic [2:0] ST_SETUP0 = 3'd2;
  localparam logic [2:0] ST_SETUP1 = 3'd3;
  localparam logic [2:0] ST_SWEEP  = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);

  logic [2:0] state;

  cell_t            mem [0:CELLS-1];
  cell_t            rdata;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  cell_t            wr_data;

  logic             lw_valid;
  logic [IDX_W-1:0] lw_idx;
  cell_t            lw_data;

  logic             s2_valid;
  logic [IDX_W-1:0] s2_idx;
  logic             s2_left;
  logic             s2_top;
  cell_t            s2_cur;

  logic [IDX_W-1:0] clr_k;

  logic [8:0]  prod_h;
  logic [8:0]  prod_v;
  logic [7:0]  ab;
  logic [8:0]  hth;
  logic [8:0]  vth;
  logic [10:0] cthr;
  logic        fail_diff;

  logic [IDX_W-1:0] rk;
  logic [3:0]       ix;
  logic [3:0]       iy;
  logic             issuing;
  logic             dv;
  logic [IDX_W-1:0] dk;
  logic [3:0]       dcx;
  logic [3:0]       dcy;
  cell_t            sl [1:20];
  logic             fh;
  logic             fv;
  logic             fd;
  logic             fc;

  logic [4:0]  hp;
  logic [4:0]  vp;
  logic [11:0] x9h;
  logic [11:0] x9v;
  logic [24:0] mh;
  logic [24:0] mv;
  logic [34:0] pc;

  logic [11:0] a_t, b_t, c_t, d_t;
  logic [11:0] h1, h2, h3, v1, v2, v3, dg1, dg2, cl;
  logic        w2, w3, hit_h, hit_v, hit_d, hit_c;
  logic        fh_n, fv_n, fd_n, fc_n;

  assign clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_RUN) && !empty && !clear;
  assign issuing  = (state == ST_SWEEP) && (rk <= LAST_IDX);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  always_comb begin
    s2_cur  = (lw_valid && lw_idx == s2_idx) ? lw_data : rdata;
    rd_addr = (state == ST_SWEEP) ? rk : entry.idx;
    wr_en   = 1'b0;
    wr_addr = s2_idx;
    wr_data = '0;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_k;
    end else if (dv) begin
      wr_en   = 1'b1;
      wr_addr = dk;
    end else if (s2_valid) begin
      wr_en        = 1'b1;
      wr_data.tot  = s2_cur.tot + CNT_W'(1);
      wr_data.left = s2_cur.left + CNT_W'(s2_left);
      wr_data.top  = s2_cur.top + CNT_W'(s2_top);
    end
  end

  always_comb begin
    hp  = div9(w_dim);
    vp  = div9(h_dim);
    x9h = {prod_h, 3'b0} + {3'b0, prod_h};
    x9v = {prod_v, 3'b0} + {3'b0, prod_v};
    mh  = {13'b0, x9h} * 25'd6554;
    mv  = {13'b0, x9v} * 25'd6554;
    pc  = {1'b0, {26'b0, ab} * {8'b0, PI_Q24}} + 35'd16777215;
  end

  always_comb begin
    a_t = 12'(sl[10].tot);
    b_t = 12'(sl[1].tot);
    c_t = 12'(sl[9].tot);
    d_t = 12'(rdata.tot);
    h1  = a_t + c_t;
    h2  = 12'(sl[10].tot - sl[10].left) + 12'(sl[9].tot - sl[9].left)
        + 12'(sl[1].left) + 12'(rdata.left);
    h3  = b_t + d_t;
    v1  = a_t + b_t;
    v2  = 12'(sl[10].tot - sl[10].top) + 12'(sl[1].tot - sl[1].top)
        + 12'(sl[9].top) + 12'(rdata.top);
    v3  = c_t + d_t;
    dg1 = 12'(sl[20].tot) + a_t + d_t;
    dg2 = 12'(sl[18].tot) + a_t + 12'(sl[2].tot);
    cl  = a_t + b_t + c_t + d_t;
    w2  = (dcx != 4'd0) && (dcy != 4'd0);
    w3  = (dcx >= 4'd2) && (dcy >= 4'd2);
    hit_h = w2 && (h1 >= 12'(hth) || h2 >= 12'(hth)
                   || (dcx == 4'(GRID - 1) && h3 >= 12'(hth)));
    hit_v = w2 && (v1 >= 12'(vth) || v2 >= 12'(vth)
                   || (dcy == 4'(GRID - 1) && v3 >= 12'(vth)));
    hit_d = w3 && (dg1 >= 12'(hth) || dg2 >= 12'(hth));
    hit_c = w2 && (cl >= {1'b0, cthr});
    fh_n  = fh || hit_h;
    fv_n  = fv || hit_v;
    fd_n  = fd || hit_d;
    fc_n  = fc || hit_c;
  end

  always_ff @(posedge clk) begin
    if (dv) begin
      sl[1] <= rdata;
      for (int n = 2; n <= 20; n++) sl[n] <= sl[n-1];
    end
    lw_data <= wr_data;
    lw_idx  <= wr_addr;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state    <= ST_CLEAR;
      clr_k    <= '0;
      s2_valid <= 1'b0;
      lw_valid <= 1'b0;
      dv       <= 1'b0;
      done     <= 1'b0;
    end else begin
      lw_valid <= wr_en;
      done     <= 1'b0;
      s2_valid <= 1'b0;
      dv       <= issuing;
      dk       <= rk;
      dcx      <= ix;
      dcy      <= iy;
      case (state)
        ST_CLEAR: begin
          clr_k <= clr_k + IDX_W'(1);
          if (clr_k == LAST_IDX) state <= ST_RUN;
        end
        ST_RUN: begin
          if (pop) begin
            s2_valid <= entry.diff;
            s2_idx   <= entry.idx;
            s2_left  <= entry.left;
            s2_top   <= entry.top;
            if (entry.last) begin
              fail_diff <= entry.diff_total > (entry.on_total >> 2);
              state     <= ST_SETUP0;
            end
          end
        end
        ST_SETUP0: begin
          prod_h <= {4'b0, hp} * {5'b0, vp[4:1]};
          prod_v <= {4'b0, vp} * {5'b0, hp[4:1]};
          ab     <= {4'b0, hp[4:1]} * {4'b0, vp[4:1]};
          state  <= ST_SETUP1;
        end
        ST_SETUP1: begin
          hth   <= mh[24:16];
          vth   <= mv[24:16];
          cthr  <= pc[34:24];
          rk    <= '0;
          ix    <= '0;
          iy    <= '0;
          fh    <= 1'b0;
          fv    <= 1'b0;
          fd    <= 1'b0;
          fc    <= 1'b0;
          state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (issuing) begin
            rk <= rk + IDX_W'(1);
            if (iy == 4'(GRID - 1)) begin
              iy <= '0;
              ix <= ix + 4'd1;
            end else begin
              iy <= iy + 4'd1;
            end
          end
          if (dv) begin
            fh <= fh_n;
            fv <= fv_n;
            fd <= fd_n;
            fc <= fc_n;
            if (dk == LAST_IDX) begin
              done  <= 1'b1;
              state <= ST_RUN;
              if (fail_diff) reject_cause <= CAUSE_DIFF;
              else if (fh_n) reject_cause <= CAUSE_HLINE;
              else if (fv_n) reject_cause <= CAUSE_VLINE;
              else if (fd_n) reject_cause <= CAUSE_DIAG;
              else if (fc_n) reject_cause <= CAUSE_CLUST;
              else reject_cause <= CAUSE_NONE;
              equivalent <= !(fail_diff || fh_n || fv_n || fd_n || fc_n);
            end
          end
        end
        default: begin
          state <= ST_CLEAR;
          clr_k <= '0;
        end
      endcase
    end
  end

endmodule

[rtl/symbol_bitmap_equivalence_check.sv]
// ----------------------------------------------------------------------------
// symbol_bitmap_equivalence_check
// Compares two 1-bit symbol bitmaps streamed as pixel pairs in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel pairs go in on first_pixel/second_pixel, taken on a clock edge with
//   start high and busy low, row 0 first, left to right.
//   image_width (index 0) and image_height (index 1) are written over the
//   cfg channel; cfg_ready is always high. A write to either register drops
//   the image in progress and runs a clear of the cell memory.
//   The front takes one pixel per cycle while busy is low; differing pixels
//   are queued (four items) and applied to the cell memory by the back at
//   one per cycle while in its run state, through a read-modify-write pipe
//   with bypass; busy rises when the queue is full or the memory is cleared.
//   Once the last pixel is taken and any differing pixels queued ahead of it
//   are applied, its event reaches the back, the thresholds are derived in
//   the setup states, one read is issued per cell of the 81-cell memory,
//   clearing each cell as it goes, and the verdict is registered. Pixels of
//   the next image are queued meanwhile.
//   The verdict is on equivalent/reject_cause, marked by done for one cycle;
//   the receiver cannot stall it.
//   After reset the cell memory is cleared with busy high.
// ----------------------------------------------------------------------------
module symbol_bitmap_equivalence_check (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         first_pixel,
  input  logic                         second_pixel,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sbec_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [sbec_pkg::DIM_W-1:0]   cfg_data,
  output logic                         done,
  output logic                         equivalent,
  output logic [sbec_pkg::CAUSE_W-1:0] reject_cause
);
  import sbec_pkg::*;

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] w_dim;
  logic [DIM_W-1:0] h_dim;
  logic             cfg_clear;
  logic             accept;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  logic             clearing;
  qent_t            f_entry;
  qent_t            q_entry;

  assign cfg_ready = 1'b1;
  assign cfg_clear = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
  assign w_dim     = eff_dim(image_width);
  assign h_dim     = eff_dim(image_height);
  assign busy      = full || clearing;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 9'd16;
      image_height <= 9'd16;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) image_width <= cfg_data;
      else if (cfg_index == REG_HEIGHT) image_height <= cfg_data;
    end
  end

  sbec_front u_front (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_clear),
    .accept       (accept),
    .first_pixel  (first_pixel),
    .second_pixel (second_pixel),
    .w_dim        (w_dim),
    .h_dim        (h_dim),
    .push         (push),
    .entry        (f_entry)
  );

  sbec_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .flush (cfg_clear),
    .push  (push),
    .wdata (f_entry),
    .pop   (pop),
    .rdata (q_entry),
    .full  (full),
    .empty (empty)
  );

  sbec_back u_back (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_clear),
    .w_dim        (w_dim),
    .h_dim        (h_dim),
    .entry        (q_entry),
    .empty        (empty),
    .pop          (pop),
    .clearing     (clearing),
    .done         (done),
    .equivalent   (equivalent),
    .reject_cause (reject_cause)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("event queue overflow");
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("verdict strobe longer than one cycle");
  a_verdict_match: assert property (@(posedge clk) disable iff (rst)
    done |-> (equivalent == (reject_cause == CAUSE_NONE)))
    else $error("verdict and cause disagree");
  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> busy)
    else $error("accepting before cell memory clear");
`endif

endmodule
